>>> hdl/redundant_brace_pair_finder_macros.svh
// assertion macros used by the checker file
`ifndef REDUNDANT_BRACE_PAIR_FINDER_MACROS_SVH
`define REDUNDANT_BRACE_PAIR_FINDER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/brf_pkg.sv
// shared constants, codes and types of the redundant brace pair finder
package brf_pkg;

	localparam int STACK_DEPTH   = 64;
	localparam int MAX_RANGE_LEN = 65536;
	localparam int FLD_W         = 16;
	localparam int ST_W          = 3;
	localparam int LVL_W         = $clog2(STACK_DEPTH + 1);
	localparam int ADR_W         = $clog2(STACK_DEPTH);
	localparam int POS_W         = $clog2(MAX_RANGE_LEN + 1);

	localparam logic [FLD_W-1:0] CH_LBRACE = 16'h007B;
	localparam logic [FLD_W-1:0] CH_RBRACE = 16'h007D;
	localparam logic [FLD_W-1:0] CH_BSLASH = 16'h005C;

	typedef enum logic [ST_W-1:0] {
		ST_RUNNING   = 3'd0,
		ST_DONE      = 3'd1,
		ST_UNMATCHED = 3'd2,
		ST_UNCLOSED  = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [LVL_W-1:0] lvl;
		logic [LVL_W-1:0] lvl_nxt;
		logic [FLD_W-1:0] wdata;
	} stk_cmd_t;

endpackage

>>> hdl/brf_stack.sv
// left brace position stack: top two entries in registers, the rest in a memory
module brf_stack (
	input  logic                      clk,
	input  brf_pkg::stk_cmd_t         cmd,
	output logic [brf_pkg::FLD_W-1:0] top_pos
);
	import brf_pkg::*;

	logic [FLD_W-1:0] mem [STACK_DEPTH];
	logic [FLD_W-1:0] top_q;
	logic [FLD_W-1:0] below_q;
	logic [FLD_W-1:0] rd_q;
	logic [LVL_W-1:0] wr_lvl;
	logic [LVL_W-1:0] rd_lvl;
	logic [ADR_W-1:0] wr_adr;
	logic [ADR_W-1:0] rd_adr;
	logic             wr_en;

	assign wr_lvl  = cmd.lvl - LVL_W'(2);
	assign rd_lvl  = cmd.lvl_nxt - LVL_W'(3);
	assign wr_adr  = wr_lvl[ADR_W-1:0];
	assign rd_adr  = rd_lvl[ADR_W-1:0];
	assign wr_en   = cmd.push && (cmd.lvl >= LVL_W'(2));
	assign top_pos = top_q;

	// spill the second entry on push, prefetch the third entry for the next pop
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_adr] <= below_q;
		end
		if (wr_en && (wr_adr == rd_adr)) begin
			rd_q <= below_q;
		end else begin
			rd_q <= mem[rd_adr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q   <= cmd.wdata;
			below_q <= top_q;
		end else if (cmd.pop) begin
			top_q   <= below_q;
			below_q <= rd_q;
		end
	end

endmodule

>>> hdl/redundant_brace_pair_finder.sv
// top level of the redundant brace pair finder
//
// input channel: one 16-bit character per word on ch, with first and last
// marking the ends of a text range; accepted when in_valid is high and
// in_stall is low
// output channel: exactly one result word per input word (redundant,
// left_pos, right_pos, status, pair_count); taken when out_valid is high and
// out_stall is low
// the result of a word is registered in the result register, or in the skid
// register while a result waits; throughput: one word per cycle while in_stall
// is low; the brace stack keeps its two top entries in registers and prefetches
// the third from its memory, so a pop or push can follow in every cycle
// a two-entry output (result register plus skid register) keeps accepting
// while one result waits; in_stall rises only when both are full
// reset: all matching state, valid flags and the skid entry clear; stack memory
// needs no clearing, it is only read below the fill level
// a word with last set ends the range: the next word starts a new one
module redundant_brace_pair_finder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [brf_pkg::FLD_W-1:0] ch,
	input  logic                      first,
	input  logic                      last,
	input  logic                      in_valid,
	output logic                      in_stall,
	output logic                      redundant,
	output logic [brf_pkg::FLD_W-1:0] left_pos,
	output logic [brf_pkg::FLD_W-1:0] right_pos,
	output logic [brf_pkg::ST_W-1:0]  status,
	output logic [brf_pkg::FLD_W-1:0] pair_count,
	output logic                      out_valid,
	input  logic                      out_stall
);
	import brf_pkg::*;

	typedef struct packed {
		logic             redundant;
		logic [FLD_W-1:0] left_pos;
		logic [FLD_W-1:0] right_pos;
		status_t          status;
		logic [FLD_W-1:0] pair_count;
	} res_t;

	logic [LVL_W-1:0] lvl_q, lvl_eff, lvl_n;
	logic [POS_W-1:0] pos_q, pos_eff, pos_n;
	logic [POS_W-1:0] pr_q, pr_eff, pr_n;
	logic [FLD_W-1:0] pl_q, pl_eff, pl_n;
	logic [FLD_W-1:0] pairs_q, pairs_eff, pairs_n;
	logic             bsl_q, bsl_eff, bsl_n;
	logic             pv_q, pv_eff, pv_n;
	status_t          err_q, err_eff, err_n;

	logic             acc;
	logic             push, pop;
	logic [FLD_W-1:0] top_pos;
	stk_cmd_t         cmd;
	res_t             res, out_q, skid_q;
	logic             skid_v_q;
	logic             out_take;

	assign acc      = in_valid && !skid_v_q;
	assign in_stall = skid_v_q;
	assign out_take = out_valid && !out_stall;

	always_comb begin
		if (first) begin
			lvl_eff   = '0;
			pos_eff   = '0;
			pr_eff    = '0;
			pl_eff    = '0;
			pairs_eff = '0;
			bsl_eff   = 1'b0;
			pv_eff    = 1'b0;
			err_eff   = ST_RUNNING;
		end else begin
			lvl_eff   = lvl_q;
			pos_eff   = pos_q;
			pr_eff    = pr_q;
			pl_eff    = pl_q;
			pairs_eff = pairs_q;
			bsl_eff   = bsl_q;
			pv_eff    = pv_q;
			err_eff   = err_q;
		end

		lvl_n   = lvl_eff;
		pos_n   = pos_eff;
		pr_n    = pr_eff;
		pl_n    = pl_eff;
		pairs_n = pairs_eff;
		bsl_n   = bsl_eff;
		pv_n    = pv_eff;
		err_n   = err_eff;
		push    = 1'b0;
		pop     = 1'b0;
		res.redundant = 1'b0;
		res.left_pos  = '0;
		res.right_pos = '0;

		if (err_eff == ST_RUNNING) begin
			if (pos_eff >= POS_W'(MAX_RANGE_LEN)) begin
				err_n = ST_OVERFLOW;
			end else begin
				if (ch == CH_LBRACE && !bsl_eff) begin
					if (lvl_eff >= LVL_W'(STACK_DEPTH)) begin
						err_n = ST_OVERFLOW;
					end else begin
						push  = 1'b1;
						lvl_n = lvl_eff + LVL_W'(1);
					end
				end else if (ch == CH_RBRACE && !bsl_eff) begin
					if (lvl_eff == '0) begin
						err_n = ST_UNMATCHED;
					end else begin
						pop   = 1'b1;
						lvl_n = lvl_eff - LVL_W'(1);
						if (pv_eff
								&& ({1'b0, pos_eff} == {1'b0, pr_eff} + (POS_W+1)'(1))
								&& ({1'b0, top_pos} + (FLD_W+1)'(1) == {1'b0, pl_eff})) begin
							res.redundant = 1'b1;
							res.left_pos  = top_pos;
							res.right_pos = pos_eff[FLD_W-1:0];
						end
						pl_n    = top_pos;
						pr_n    = pos_eff;
						pv_n    = 1'b1;
						pairs_n = pairs_eff + FLD_W'(1);
					end
				end
				bsl_n = (ch == CH_BSLASH);
				pos_n = pos_eff + POS_W'(1);
			end
		end

		if (err_n != ST_RUNNING) begin
			res.status = err_n;
		end else if (last) begin
			res.status = (lvl_n != '0) ? ST_UNCLOSED : ST_DONE;
		end else begin
			res.status = ST_RUNNING;
		end
		res.pair_count = pairs_n;

		// range end returns everything to its reset values
		if (last) begin
			lvl_n   = '0;
			pos_n   = '0;
			pr_n    = '0;
			pl_n    = '0;
			pairs_n = '0;
			bsl_n   = 1'b0;
			pv_n    = 1'b0;
			err_n   = ST_RUNNING;
		end
	end

	always_comb begin
		cmd.push    = acc && push;
		cmd.pop     = acc && pop;
		cmd.lvl     = acc ? lvl_eff : lvl_q;
		cmd.lvl_nxt = acc ? lvl_n : lvl_q;
		cmd.wdata   = pos_eff[FLD_W-1:0];
	end

	brf_stack u_stack (
		.clk     (clk),
		.cmd     (cmd),
		.top_pos (top_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			pos_q   <= '0;
			pr_q    <= '0;
			pl_q    <= '0;
			pairs_q <= '0;
			bsl_q   <= 1'b0;
			pv_q    <= 1'b0;
			err_q   <= ST_RUNNING;
		end else if (acc) begin
			lvl_q   <= lvl_n;
			pos_q   <= pos_n;
			pr_q    <= pr_n;
			pl_q    <= pl_n;
			pairs_q <= pairs_n;
			bsl_q   <= bsl_n;
			pv_q    <= pv_n;
			err_q   <= err_n;
		end
	end

	// result register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (out_valid && !out_take) begin
			if (acc) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_valid <= 1'b1;
			skid_v_q  <= 1'b0;
		end else begin
			out_valid <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && !out_take) begin
			if (acc) begin
				skid_q <= res;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (acc) begin
			out_q <= res;
		end
	end

	assign redundant  = out_q.redundant;
	assign left_pos   = out_q.left_pos;
	assign right_pos  = out_q.right_pos;
	assign status     = out_q.status;
	assign pair_count = out_q.pair_count;

endmodule

>>> hdl/brf_checker.sv
// port-level checker of the redundant brace pair finder and its bind
`include "redundant_brace_pair_finder_macros.svh"

module brf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      redundant,
	input logic [brf_pkg::FLD_W-1:0] left_pos,
	input logic [brf_pkg::FLD_W-1:0] right_pos,
	input logic [brf_pkg::ST_W-1:0]  status,
	input logic [brf_pkg::FLD_W-1:0] pair_count,
	input logic                      out_valid,
	input logic                      out_stall
);
	import brf_pkg::*;

	`BRF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pair_count) && $stable(status), "stalled result word changed or vanished")
	`BRF_ASSERT_IMPL(a_stall_cause, in_stall, $past(out_valid && out_stall), "input stalled without a held result word")
	`BRF_ASSERT_IMPL(a_red_status, out_valid && redundant, (status == ST_RUNNING || status == ST_DONE || status == ST_UNCLOSED) && (right_pos > left_pos), "redundant pair reported with error status or bad positions")
	`BRF_ASSERT_IMPL(a_pos_zero, out_valid && !redundant, left_pos == '0 && right_pos == '0, "positions set without a redundant pair")

endmodule

bind redundant_brace_pair_finder brf_checker u_brf_checker (.*);

>>> verif/redundant_brace_pair_finder_tb.sv
// self-checking testbench for the redundant brace pair finder
module redundant_brace_pair_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [FLD_W-1:0] ch;
		logic             first;
		logic             last;
	} brace_word_t;

	typedef struct packed {
		logic             redundant;
		logic [FLD_W-1:0] left_pos;
		logic [FLD_W-1:0] right_pos;
		status_t          status;
		logic [FLD_W-1:0] pair_count;
	} finder_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic [FLD_W-1:0] ch = '0;
	logic             first = 1'b0;
	logic             last = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             redundant;
	logic [FLD_W-1:0] left_pos;
	logic [FLD_W-1:0] right_pos;
	logic [ST_W-1:0]  status;
	logic [FLD_W-1:0] pair_count;
	logic             out_valid;
	logic             out_stall = 1'b0;

	redundant_brace_pair_finder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.first      (first),
		.last       (last),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.redundant  (redundant),
		.left_pos   (left_pos),
		.right_pos  (right_pos),
		.status     (status),
		.pair_count (pair_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	brace_word_t    pending_words[$];
	finder_result_t expected_results[$];
	logic [FLD_W-1:0] range_chars[$];
	logic in_fire = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   calm_left = 0;
	int   fail_count = 0;
	int   cycle_count = 0;

	// matching state of the predictor
	logic [FLD_W-1:0] open_pos [STACK_DEPTH];
	int unsigned      open_cnt;
	int unsigned      char_pos;
	bit               after_bslash;
	int unsigned      last_left;
	int unsigned      last_right;
	bit               have_pair;
	logic [FLD_W-1:0] pair_total;
	status_t          sticky_err;

	function automatic void clear_matching();
		open_cnt = 0;
		char_pos = 0;
		after_bslash = 1'b0;
		last_left = 0;
		last_right = 0;
		have_pair = 1'b0;
		pair_total = '0;
		sticky_err = ST_RUNNING;
	endfunction

	initial clear_matching();

	function automatic finder_result_t predict_match(logic [FLD_W-1:0] c, logic f, logic l);
		finder_result_t r;
		logic [FLD_W-1:0] lp;
		r = '0;
		if (f)
			clear_matching();
		if (sticky_err == ST_RUNNING) begin
			if (char_pos >= MAX_RANGE_LEN) begin
				sticky_err = ST_OVERFLOW;
			end else begin
				if (c == CH_LBRACE && !after_bslash) begin
					if (open_cnt >= STACK_DEPTH) begin
						sticky_err = ST_OVERFLOW;
					end else begin
						open_pos[open_cnt] = char_pos[FLD_W-1:0];
						open_cnt++;
					end
				end else if (c == CH_RBRACE && !after_bslash) begin
					if (open_cnt == 0) begin
						sticky_err = ST_UNMATCHED;
					end else begin
						open_cnt--;
						lp = open_pos[open_cnt];
						if (have_pair && char_pos == last_right + 1 &&
								32'(lp) + 1 == last_left) begin
							r.redundant = 1'b1;
							r.left_pos = lp;
							r.right_pos = char_pos[FLD_W-1:0];
						end
						last_left = lp;
						last_right = char_pos;
						have_pair = 1'b1;
						pair_total = pair_total + 1'b1;
					end
				end
				after_bslash = (c == CH_BSLASH);
				char_pos++;
			end
		end
		if (sticky_err != ST_RUNNING)
			r.status = sticky_err;
		else if (l)
			r.status = (open_cnt != 0) ? ST_UNCLOSED : ST_DONE;
		else
			r.status = ST_RUNNING;
		r.pair_count = pair_total;
		if (l)
			clear_matching();
		return r;
	endfunction

	task report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// driver
	always @(negedge clk) begin : word_driver
		brace_word_t nxt;
		if (arst_n) begin
			if (calm_left > 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(0, 199) == 0)
				calm_left <= $urandom_range(10, 60);
			out_stall <= (calm_left == 0) && ($urandom_range(0, 99) < recv_idle_pct);
			if (!in_valid || in_fire) begin
				if (pending_words.size() != 0 &&
						(calm_left != 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
					nxt = pending_words.pop_front();
					ch <= nxt.ch;
					first <= nxt.first;
					last <= nxt.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : result_check
		finder_result_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none pending", 0, 0);
				end else begin
					want = expected_results.pop_front();
					if (redundant !== want.redundant)
						report_mismatch("redundant", redundant, want.redundant);
					if (left_pos !== want.left_pos)
						report_mismatch("left_pos", left_pos, want.left_pos);
					if (right_pos !== want.right_pos)
						report_mismatch("right_pos", right_pos, want.right_pos);
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (pair_count !== want.pair_count)
						report_mismatch("pair_count", pair_count, want.pair_count);
				end
			end
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
					predict_match(ch, first, last));
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("redundant_brace_pair_finder verification failed");
				$finish;
			end
		end
	end

	task push_word(logic [FLD_W-1:0] c, bit f, bit l);
		brace_word_t w;
		w.ch = c;
		w.first = f;
		w.last = l;
		pending_words.insert(pending_words.size(), w);
	endtask

	task push_range(bit with_first, bit with_last);
		for (int i = 0; i < range_chars.size(); i++)
			push_word(range_chars[i], with_first && i == 0,
				with_last && i == range_chars.size() - 1);
	endtask

	task add_char(logic [FLD_W-1:0] c);
		range_chars.insert(range_chars.size(), c);
	endtask

	task push_string(string s, bit with_first, bit with_last);
		range_chars.delete();
		for (int i = 0; i < s.len(); i++)
			add_char({8'h00, s[i]});
		push_range(with_first, with_last);
	endtask

	function automatic logic [FLD_W-1:0] plain_char();
		case ($urandom_range(0, 3))
			0: return 16'h0020;
			3: return 16'($urandom_range(0, 16'hFFFF));
			default: return 16'($urandom_range(16'h0061, 16'h007A));
		endcase
	endfunction

	function automatic logic [FLD_W-1:0] escapable_char();
		case ($urandom_range(0, 2))
			0: return CH_LBRACE;
			1: return CH_RBRACE;
			default: return CH_BSLASH;
		endcase
	endfunction

	// text with mostly balanced braces, nested runs and escapes
	task automatic append_text(int units, bit close_all);
		int depth;
		int r;
		int k;
		depth = 0;
		repeat (units) begin
			r = $urandom_range(0, 99);
			if (r < 18 && depth < 56) begin
				add_char(CH_LBRACE);
				depth++;
			end else if (r < 36 && depth > 0) begin
				add_char(CH_RBRACE);
				depth--;
			end else if (r < 48 && depth < 56) begin
				k = $urandom_range(2, 4);
				repeat (k) add_char(CH_LBRACE);
				if ($urandom_range(0, 2) != 0)
					add_char(plain_char());
				repeat (k) add_char(CH_RBRACE);
			end else if (r < 56) begin
				add_char(CH_BSLASH);
				add_char(escapable_char());
				add_char(16'($urandom_range(16'h0061, 16'h007A)));
			end else begin
				add_char(plain_char());
			end
		end
		if (close_all)
			repeat (depth) add_char(CH_RBRACE);
	endtask

	task automatic add_random_words(int target);
		int start;
		int kind;
		logic [FLD_W-1:0] esc;
		start = pending_words.size();
		while (pending_words.size() < start + target) begin
			kind = $urandom_range(0, 99);
			range_chars.delete();
			if (kind < 56) begin
				append_text($urandom_range(1, 30), 1'b1);
				push_range(1'b1, 1'b1);
			end else if (kind < 64) begin
				// unmatched right brace, then more text
				append_text($urandom_range(0, 12), 1'b1);
				add_char(CH_RBRACE);
				append_text($urandom_range(0, 6), 1'b0);
				push_range(1'b1, 1'b1);
			end else if (kind < 72) begin
				// left braces left open
				add_char(CH_LBRACE);
				append_text($urandom_range(0, 15), 1'b0);
				push_range(1'b1, 1'b1);
			end else if (kind < 75) begin
				// stack overflow
				repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 6))
					add_char(CH_LBRACE);
				append_text($urandom_range(0, 4), 1'b1);
				push_range(1'b1, 1'b1);
			end else if (kind < 83) begin
				// range without first mark
				append_text($urandom_range(1, 20), 1'b1);
				push_range(1'b0, 1'b1);
			end else if (kind < 90) begin
				// range restarted before its end
				append_text($urandom_range(1, 10), 1'b0);
				push_range(1'b1, 1'b0);
				range_chars.delete();
				append_text($urandom_range(1, 15), 1'b1);
				push_range(1'b1, 1'b1);
			end else begin
				// noise with random marks
				repeat ($urandom_range(1, 20)) begin
					if ($urandom_range(0, 2) == 0) begin
						esc = escapable_char();
						push_word({8'($urandom_range(0, 255)), esc[7:0]},
							$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
					end else begin
						push_word(16'($urandom_range(0, 16'hFFFF)),
							$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
					end
				end
			end
		end
	endtask

	task wait_all_done();
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 6;
		recv_idle_pct = 73;
		push_string("{{a}}", 1'b1, 1'b1);
		push_string("}", 1'b1, 1'b1);
		push_string("{", 1'b1, 1'b1);
		push_string("\\{}{", 1'b1, 1'b1);
		push_string("{}", 1'b0, 1'b1);
		push_string("{\\}}", 1'b1, 1'b1);
		push_string("{{", 1'b1, 1'b0);
		push_string("{}", 1'b1, 1'b1);
		push_word(16'hFFFF, 1'b1, 1'b0);
		push_word(16'h0000, 1'b0, 1'b1);
		add_random_words(310);
		wait_all_done();

		send_idle_pct = 73;
		recv_idle_pct = 6;
		add_random_words(310);
		wait_all_done();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_words(310);
		wait_all_done();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("redundant_brace_pair_finder verification clean");
		else
			$display("redundant_brace_pair_finder verification failed");
		$finish;
	end

endmodule
